[rtl/radio_api_frame_builder_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the radio API frame builder checks
// ----------------------------------------------------------------------------
`ifndef RADIO_API_FRAME_BUILDER_TOP_MACROS_SVH
`define RADIO_API_FRAME_BUILDER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define RAFB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rafb check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define RAFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rafb check failed: next-cycle implication");

`endif

[rtl/rafb_pkg.sv]
// ----------------------------------------------------------------------------
// rafb_pkg
// Types and constants shared by the radio API frame builder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rafb_pkg;

  // most bytes one input word can produce (transmit header plus checksum)
  localparam int unsigned MAX_BYTES = 9;
  localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);

  // input command codes
  typedef enum logic [1:0] {
    CMD_TX   = 2'd0,
    CMD_AT   = 2'd1,
    CMD_DATA = 2'd2
  } cmd_t;

  // configuration register indexes
  localparam logic [1:0] REG_ID_BYTE = 2'd0;
  localparam logic [1:0] REG_DEST    = 2'd1;
  localparam logic [1:0] REG_OPTIONS = 2'd2;

  // frame constants
  localparam logic [7:0] DELIM   = 8'h7E;
  localparam logic [7:0] TYPE_TX = 8'h01;
  localparam logic [7:0] TYPE_AT = 8'h08;
  localparam logic [8:0] HDR_TX  = 9'd5;
  localparam logic [8:0] HDR_AT  = 9'd4;

  // one built burst of output bytes, handed from builder to emitter
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          cnt;
    logic                      has_end;
  } entry_t;

endpackage

`default_nettype wire

[rtl/rafb_build.sv]
// ----------------------------------------------------------------------------
// rafb_build
// Holds configuration and frame state, turns each accepted input word that
// yields bytes into a registered burst of output bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module rafb_build (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 acc,
  input  wire logic [1:0]           cmd,
  input  wire logic [7:0]           payload_length,
  input  wire logic [7:0]           at_char_1,
  input  wire logic [7:0]           at_char_2,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 ent_done,
  output rafb_pkg::entry_t          ent,
  output logic                      ent_valid
);

  logic [7:0]  id_byte;
  logic [15:0] dest_address;
  logic [7:0]  tx_options;

  logic        frame_open, frame_open_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  running_sum, running_sum_next;

  rafb_pkg::entry_t ent_next;
  logic [8:0]  len;
  logic [7:0]  hsum;
  logic [7:0]  psum;
  logic        last_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      id_byte      <= 8'd0;
      dest_address <= 16'd0;
      tx_options   <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rafb_pkg::REG_ID_BYTE: id_byte      <= cfg_data[7:0];
        rafb_pkg::REG_DEST:    dest_address <= cfg_data;
        rafb_pkg::REG_OPTIONS: tx_options   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // burst contents and next frame state
  always_comb begin
    len = {1'b0, payload_length} +
          ((cmd == rafb_pkg::CMD_TX) ? rafb_pkg::HDR_TX : rafb_pkg::HDR_AT);
    if (cmd == rafb_pkg::CMD_TX) begin
      hsum = rafb_pkg::TYPE_TX + id_byte + dest_address[15:8] + dest_address[7:0]
             + tx_options;
    end else begin
      hsum = rafb_pkg::TYPE_AT + id_byte + at_char_1 + at_char_2;
    end
    psum      = running_sum + data_byte;
    last_data = (bytes_left == 8'd1);

    ent_next          = '0;
    frame_open_next   = frame_open;
    bytes_left_next   = bytes_left;
    running_sum_next  = running_sum;

    unique case (rafb_pkg::cmd_t'(cmd))
      rafb_pkg::CMD_TX: begin
        ent_next.bytes[0] = rafb_pkg::DELIM;
        ent_next.bytes[1] = {7'd0, len[8]};
        ent_next.bytes[2] = len[7:0];
        ent_next.bytes[3] = rafb_pkg::TYPE_TX;
        ent_next.bytes[4] = id_byte;
        ent_next.bytes[5] = dest_address[15:8];
        ent_next.bytes[6] = dest_address[7:0];
        ent_next.bytes[7] = tx_options;
        ent_next.bytes[8] = ~hsum;
        ent_next.has_end  = (payload_length == 8'd0);
        ent_next.cnt      = ent_next.has_end ? rafb_pkg::CNT_W'(9) : rafb_pkg::CNT_W'(8);
        frame_open_next   = !ent_next.has_end;
        bytes_left_next   = payload_length;
        running_sum_next  = ent_next.has_end ? 8'd0 : hsum;
      end
      rafb_pkg::CMD_AT: begin
        ent_next.bytes[0] = rafb_pkg::DELIM;
        ent_next.bytes[1] = {7'd0, len[8]};
        ent_next.bytes[2] = len[7:0];
        ent_next.bytes[3] = rafb_pkg::TYPE_AT;
        ent_next.bytes[4] = id_byte;
        ent_next.bytes[5] = at_char_1;
        ent_next.bytes[6] = at_char_2;
        ent_next.bytes[7] = ~hsum;
        ent_next.has_end  = (payload_length == 8'd0);
        ent_next.cnt      = ent_next.has_end ? rafb_pkg::CNT_W'(8) : rafb_pkg::CNT_W'(7);
        frame_open_next   = !ent_next.has_end;
        bytes_left_next   = payload_length;
        running_sum_next  = ent_next.has_end ? 8'd0 : hsum;
      end
      rafb_pkg::CMD_DATA: begin
        // payload outside a frame is dropped
        if (frame_open) begin
          ent_next.bytes[0] = data_byte;
          ent_next.bytes[1] = ~psum;
          ent_next.has_end  = last_data;
          ent_next.cnt      = last_data ? rafb_pkg::CNT_W'(2) : rafb_pkg::CNT_W'(1);
          frame_open_next   = !last_data;
          bytes_left_next   = last_data ? 8'd0 : bytes_left - 8'd1;
          running_sum_next  = last_data ? 8'd0 : psum;
        end
      end
      default: ;  // unused code: ignored
    endcase
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      bytes_left  <= 8'd0;
      running_sum <= 8'd0;
    end else if (acc) begin
      frame_open  <= frame_open_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
    end
  end

  // burst register: loads on a word that produces bytes, frees when emitted
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (acc && (ent_next.cnt != '0)) begin
      ent_valid <= 1'b1;
    end else if (ent_done) begin
      ent_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ent <= ent_next;
    end
  end

endmodule

`default_nettype wire

[rtl/rafb_emit.sv]
// ----------------------------------------------------------------------------
// rafb_emit
// Walks a registered burst a byte per unstalled cycle to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rafb_emit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rafb_pkg::entry_t     ent,
  input  wire logic                 ent_valid,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [7:0]                out_byte,
  output logic                      frame_end,
  output logic                      ent_done
);

  logic [rafb_pkg::CNT_W-1:0] idx;
  logic                       move;
  logic                       last;

  // a byte moves when the output register is empty or being drained
  assign move     = ent_valid && (!out_valid || out_ready);
  assign last     = ((idx + rafb_pkg::CNT_W'(1)) == ent.cnt);
  assign ent_done = move && last;

  // byte index within the burst
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (move) begin
      idx <= last ? '0 : idx + rafb_pkg::CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte  <= ent.bytes[idx];
      frame_end <= ent.has_end && last;
    end
  end

endmodule

`default_nettype wire

[rtl/radio_api_frame_builder_top.sv]
// ----------------------------------------------------------------------------
// radio_api_frame_builder_top
// Builds radio API frames (transmit or AT command) as a byte stream.
// ----------------------------------------------------------------------------
//  port group   dir  handshake            contents
//  cfg          in   cfg_we               cfg_index, cfg_data
//  in           in   in_valid / in_ready  cmd, payload_length, at_char_*, data_byte
//  out          out  out_valid / out_ready out_byte, frame_end
//
//  A taken word that yields bytes loads the burst register; its 1 to 9 bytes
//  follow one per cycle, while out_ready lets the output register drain,
//  through the output register. A payload word yields one byte, the one that
//  closes a frame two (checksum), a start word 7 to 9 (header, maybe checksum).
//  Synchronous reset clears frame state, configuration and both valid flags.
//  out_ready low freezes the output register and then input acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_api_frame_builder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  payload_length,
  input  wire logic [7:0]  at_char_1,
  input  wire logic [7:0]  at_char_2,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             frame_end
);

  rafb_pkg::entry_t ent;
  logic             ent_valid;
  logic             ent_done;
  logic             acc;

  // take a word when the burst register is empty or freeing this cycle
  assign in_ready = !ent_valid || ent_done;
  assign acc      = in_valid && in_ready;

  rafb_build u_build (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .acc            (acc),
    .cmd            (cmd),
    .payload_length (payload_length),
    .at_char_1      (at_char_1),
    .at_char_2      (at_char_2),
    .data_byte      (data_byte),
    .ent_done       (ent_done),
    .ent            (ent),
    .ent_valid      (ent_valid)
  );

  rafb_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .ent       (ent),
    .ent_valid (ent_valid),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .frame_end (frame_end),
    .ent_done  (ent_done)
  );

endmodule

`default_nettype wire

[rtl/rafb_chk.sv]
// ----------------------------------------------------------------------------
// rafb_chk
// Port-level checks for the frame builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radio_api_frame_builder_top_macros.svh"

module rafb_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  cmd,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_byte,
  input wire logic        frame_end
);

  // a stalled output word stays put
  `RAFB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(frame_end))

  // a start word is followed by a header burst that blocks input
  `RAFB_ASSERT_NEXT(a_start_blocks, clk, rst, in_valid && in_ready && (cmd == rafb_pkg::CMD_TX || cmd == rafb_pkg::CMD_AT), !in_ready)

  // a held burst with an empty output register always produces a byte
  `RAFB_ASSERT_NEXT(a_burst_moves, clk, rst, !in_ready && !out_valid, out_valid)

endmodule

bind radio_api_frame_builder_top rafb_chk u_chk (.*);

`default_nettype wire
